FILE: hw/rtl/owbm_pkg.sv
// Shared types and constants for the one-wire bus master.
// Depends on nothing; the front, queue and back-end modules import it.
package owbm_pkg;

   localparam int CFG_W              = 12;
   localparam int CFG_COUNT          = 8;
   localparam int CFG_IDX_W          = 3;
   localparam int TIME_BITS_DEFAULT  = 12;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // request codes on the input channel
   localparam logic [2:0] REQ_TICK        = 3'd0;
   localparam logic [2:0] REQ_RESET       = 3'd1;
   localparam logic [2:0] REQ_WRITE       = 3'd2;
   localparam logic [2:0] REQ_WRITE_PU    = 3'd3;
   localparam logic [2:0] REQ_READ        = 3'd4;
   localparam logic [2:0] REQ_SET_PU      = 3'd5;

   // configuration register indexes
   localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW   = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_RESET_WAIT  = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ONE   = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ZERO  = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_SLOT        = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW    = 3'd5;
   localparam logic [CFG_IDX_W-1:0] CFG_READ_WAIT   = 3'd6;
   localparam logic [CFG_IDX_W-1:0] CFG_PULLUP      = 3'd7;

   // configuration reset values
   localparam logic [CFG_W-1:0] RST_RESET_LOW  = 12'd480;
   localparam logic [CFG_W-1:0] RST_RESET_WAIT = 12'd80;
   localparam logic [CFG_W-1:0] RST_WRITE_ONE  = 12'd6;
   localparam logic [CFG_W-1:0] RST_WRITE_ZERO = 12'd60;
   localparam logic [CFG_W-1:0] RST_SLOT       = 12'd70;
   localparam logic [CFG_W-1:0] RST_READ_LOW   = 12'd6;
   localparam logic [CFG_W-1:0] RST_READ_WAIT  = 12'd9;

   localparam logic [7:0] BYTE_MSB = 8'h80;
   localparam logic [7:0] BYTE_LSB = 8'h01;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] data_byte;
      logic       bus_level;
      logic       pullup_request;
   } owbm_req_type;

   typedef struct packed {
      logic       drive_low;
      logic       strong_pullup_on;
      logic       busy_res;
      logic       done_res;
      logic [7:0] byte_read;
      logic       reset_sample_high;
      logic       rejected;
   } owbm_rsp_type;

   // classified item as it travels from front to back end
   typedef enum logic [2:0] {
      KIND_TICK,
      KIND_RESET,
      KIND_WRITE,
      KIND_WRITE_PU,
      KIND_READ,
      KIND_SET_PU,
      KIND_NONE
   } owbm_kind_type;

   typedef struct packed {
      owbm_kind_type kind;
      logic [7:0]    data_byte;
      logic          bus_level;
      logic          pullup_request;
   } owbm_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } owbm_qstat_type;

endpackage

FILE: hw/rtl/owbm_queue.sv
// Short item queue between the front end and the back end.
// Depends on owbm_pkg for the item and status types.
module owbm_queue
   import owbm_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  owbm_item_type  push_item,
   input  logic           pop,
   output owbm_item_type  pop_item,
   output owbm_qstat_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   owbm_item_type    entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);

endmodule

FILE: hw/rtl/owbm_front.sv
// Front end: takes request transfers and classifies them for the back end.
// Depends on owbm_pkg for the request, item and queue status types.
module owbm_front
   import owbm_pkg::*;
(
   input  logic           req_valid,
   output logic           req_stall,
   input  owbm_req_type   req_data,
   input  owbm_qstat_type qstat,
   output logic           push,
   output owbm_item_type  push_item
);

   owbm_kind_type kind;

   always_comb begin
      unique case (req_data.req_type)
         REQ_TICK:     kind = KIND_TICK;
         REQ_RESET:    kind = KIND_RESET;
         REQ_WRITE:    kind = KIND_WRITE;
         REQ_WRITE_PU: kind = KIND_WRITE_PU;
         REQ_READ:     kind = KIND_READ;
         REQ_SET_PU:   kind = KIND_SET_PU;
         default:      kind = KIND_NONE;
      endcase
   end

   assign req_stall                = qstat.full;
   assign push                     = req_valid && !qstat.full;
   assign push_item.kind           = kind;
   assign push_item.data_byte      = req_data.data_byte;
   assign push_item.bus_level      = req_data.bus_level;
   assign push_item.pullup_request = req_data.pullup_request;

endmodule

FILE: hw/rtl/owbm_back.sv
// Back end: slot timing engine, configuration registers and result register.
// Depends on owbm_pkg for the item, response and configuration constants.
module owbm_back
   import owbm_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  owbm_qstat_type       qstat,
   input  owbm_item_type        item,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output owbm_rsp_type         rsp_data
);

   localparam int CW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
   localparam logic [CW-1:0] TMAX = CW'((1 << TIME_BITS) - 1);
   localparam logic [TIME_BITS-1:0] T_ONE = TIME_BITS'(1);
   localparam logic [2:0] LAST_BIT = 3'd7;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_RESET,
      OP_WRITE,
      OP_WRITE_PU,
      OP_READ
   } op_type;

   function automatic logic [TIME_BITS-1:0] clamp_time(input logic [CFG_W-1:0] v);
      logic [CW-1:0] ext;
      ext = CW'(v);
      clamp_time = (ext > TMAX) ? TMAX[TIME_BITS-1:0] : ext[TIME_BITS-1:0];
   endfunction

   function automatic logic [CFG_W-1:0] write_wait(input logic [CFG_W-1:0] slot,
                                                   input logic [CFG_W-1:0] low);
      write_wait = (slot > low) ? slot - low : '0;
   endfunction

   // configuration
   logic [CFG_W-1:0] reset_low_ff, reset_wait_ff, write_one_ff, write_zero_ff;
   logic [CFG_W-1:0] slot_ff, read_low_ff, read_wait_ff;
   logic             pullup_present_ff;

   // engine state
   op_type               op_ff, op_in;
   logic                 phase_ff, phase_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [2:0]           bit_ff, bit_in;
   logic [7:0]           shift_ff, shift_in;
   logic                 pullup_ff, pullup_in;
   logic                 presence_ff, presence_in;
   logic                 line_ff, line_in;
   logic [7:0]           result_ff, result_in;
   logic                 rsp_valid_ff;
   owbm_rsp_type         rsp_data_ff, rsp_data_in;

   logic [TIME_BITS-1:0] t_reset_low, t_reset_wait, t_one_low, t_zero_low;
   logic [TIME_BITS-1:0] t_read_low, t_read_wait, t_one_wait, t_zero_wait;
   logic                 done, rejected, busy;
   logic [7:0]           read_shift;

   assign t_reset_low  = clamp_time(reset_low_ff);
   assign t_reset_wait = clamp_time(reset_wait_ff);
   assign t_one_low    = clamp_time(write_one_ff);
   assign t_zero_low   = clamp_time(write_zero_ff);
   assign t_read_low   = clamp_time(read_low_ff);
   assign t_read_wait  = clamp_time(read_wait_ff);
   assign t_one_wait   = clamp_time(write_wait(slot_ff, write_one_ff));
   assign t_zero_wait  = clamp_time(write_wait(slot_ff, write_zero_ff));

   assign pop        = !qstat.empty && (!rsp_valid_ff || !rsp_stall);
   assign busy       = (op_ff != OP_IDLE);
   assign read_shift = (shift_ff >> 1) | (item.bus_level ? BYTE_MSB : 8'h00);

   always_comb begin
      op_in       = op_ff;
      phase_in    = phase_ff;
      time_in     = time_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      pullup_in   = pullup_ff;
      presence_in = presence_ff;
      line_in     = line_ff;
      result_in   = result_ff;
      done        = 1'b0;
      rejected    = 1'b0;

      case (item.kind)
         KIND_TICK: begin
            if (busy) begin
               if (!phase_ff) begin
                  if (time_ff <= T_ONE) begin
                     // end of low phase: release and start the wait
                     line_in  = 1'b0;
                     phase_in = 1'b1;
                     case (op_ff)
                        OP_RESET: time_in = t_reset_wait;
                        OP_READ:  time_in = t_read_wait;
                        default:  time_in = (|(shift_ff & BYTE_LSB)) ? t_one_wait
                                                                     : t_zero_wait;
                     endcase
                     if (op_ff == OP_WRITE_PU && bit_ff == LAST_BIT && pullup_present_ff) begin
                        pullup_in = 1'b1;
                     end
                  end else begin
                     time_in = time_ff - T_ONE;
                  end
               end else if (time_ff > T_ONE) begin
                  time_in = time_ff - T_ONE;
               end else begin
                  // end of slot
                  if (op_ff == OP_RESET) begin
                     presence_in = item.bus_level;
                     done        = 1'b1;
                  end else if (op_ff == OP_READ) begin
                     shift_in = read_shift;
                     if (bit_ff == LAST_BIT) begin
                        result_in = read_shift;
                        done      = 1'b1;
                     end
                  end else if (bit_ff == LAST_BIT) begin
                     done = 1'b1;
                  end else begin
                     shift_in = shift_ff >> 1;
                  end
                  if (done) begin
                     op_in    = OP_IDLE;
                     phase_in = 1'b0;
                     time_in  = '0;
                     bit_in   = '0;
                     line_in  = 1'b0;
                  end else begin
                     // next slot starts low on this same tick
                     bit_in   = bit_ff + 3'd1;
                     line_in  = 1'b1;
                     phase_in = 1'b0;
                     if (op_ff == OP_READ) begin
                        time_in = t_read_low;
                     end else begin
                        time_in = shift_ff[1] ? t_one_low : t_zero_low;
                     end
                  end
               end
            end
         end
         KIND_RESET, KIND_WRITE, KIND_WRITE_PU, KIND_READ: begin
            if (busy) begin
               rejected = 1'b1;
            end else begin
               bit_in   = '0;
               line_in  = 1'b1;
               phase_in = 1'b0;
               if (item.kind == KIND_RESET) begin
                  op_in   = OP_RESET;
                  time_in = t_reset_low;
               end else if (item.kind == KIND_READ) begin
                  op_in    = OP_READ;
                  shift_in = '0;
                  time_in  = t_read_low;
               end else begin
                  op_in    = (item.kind == KIND_WRITE) ? OP_WRITE : OP_WRITE_PU;
                  shift_in = item.data_byte;
                  time_in  = (|(item.data_byte & BYTE_LSB)) ? t_one_low : t_zero_low;
               end
            end
         end
         KIND_SET_PU: begin
            if (busy) begin
               rejected = 1'b1;
            end else begin
               if (pullup_present_ff) begin
                  pullup_in = item.pullup_request;
               end
               done = 1'b1;
            end
         end
         default: begin
         end
      endcase

      rsp_data_in.drive_low         = line_in;
      rsp_data_in.strong_pullup_on  = pullup_in & pullup_present_ff;
      rsp_data_in.busy_res          = (op_in != OP_IDLE);
      rsp_data_in.done_res          = done;
      rsp_data_in.byte_read         = result_in;
      rsp_data_in.reset_sample_high = presence_in;
      rsp_data_in.rejected          = rejected;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= OP_IDLE;
         phase_ff     <= 1'b0;
         time_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         pullup_ff    <= 1'b0;
         presence_ff  <= 1'b1;
         line_ff      <= 1'b0;
         result_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         op_ff        <= op_in;
         phase_ff     <= phase_in;
         time_ff      <= time_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         pullup_ff    <= pullup_in;
         presence_ff  <= presence_in;
         line_ff      <= line_in;
         result_ff    <= result_in;
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff      <= RST_RESET_LOW;
         reset_wait_ff     <= RST_RESET_WAIT;
         write_one_ff      <= RST_WRITE_ONE;
         write_zero_ff     <= RST_WRITE_ZERO;
         slot_ff           <= RST_SLOT;
         read_low_ff       <= RST_READ_LOW;
         read_wait_ff      <= RST_READ_WAIT;
         pullup_present_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CFG_RESET_LOW:  reset_low_ff      <= csr_wdata;
            CFG_RESET_WAIT: reset_wait_ff     <= csr_wdata;
            CFG_WRITE_ONE:  write_one_ff      <= csr_wdata;
            CFG_WRITE_ZERO: write_zero_ff     <= csr_wdata;
            CFG_SLOT:       slot_ff           <= csr_wdata;
            CFG_READ_LOW:   read_low_ff       <= csr_wdata;
            CFG_READ_WAIT:  read_wait_ff      <= csr_wdata;
            CFG_PULLUP:     pullup_present_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/one_wire_bus_master.sv
// One-wire bus master, one item per microsecond tick or command.
// A result passes from its request transfer through a queue entry and then the
// result register. The back end takes one item per cycle while the result
// register is not held by rsp_stall. Synchronous active-high reset empties the
// queue, idles the engine and restores the register defaults.
// Top level; depends on owbm_pkg, owbm_front, owbm_queue and owbm_back.
module one_wire_bus_master
   import owbm_pkg::*;
#(
   parameter int TIME_BITS   = TIME_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  owbm_req_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output owbm_rsp_type         rsp_data,
   input  logic                 csr_we,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   owbm_qstat_type qstat;
   owbm_item_type  push_item, pop_item;
   logic           push, pop;

   owbm_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .qstat     (qstat),
      .push      (push),
      .push_item (push_item)
   );

   owbm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (qstat)
   );

   owbm_back #(
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .qstat     (qstat),
      .item      (pop_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the one-wire bus master: directed table, then random phases.
// Depends on owbm_pkg and one_wire_bus_master; carries its own model of the slot engine.
module tb;
   import owbm_pkg::*;

   localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
   localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

   localparam int PHASE_COUNT    = 10;
   localparam int PHASE_ITEMS    = 70;
   localparam int LONG_PHASE     = 2;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_PAUSE    = 4;
   localparam int MAX_GAP        = 6;
   localparam int MAX_BURST      = 24;
   localparam int MAX_PRINTS     = 40;
   localparam logic [CFG_W-1:0] LONG_TIME = 12'd6;

   typedef enum logic [2:0] {OP_IDLE, OP_RESET, OP_WRITE, OP_WRITE_PU, OP_READ} bus_op_type;
   typedef enum logic {PH_LOW, PH_WAIT} slot_ph_type;

   typedef struct packed {
      logic          reconfig;
      owbm_req_type  it;
      logic          lit_en;
      owbm_rsp_type  lit;
      logic          drain;
      logic          drain_level;
   } dir_row_type;

   localparam owbm_rsp_type NO_RSP = '0;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   owbm_req_type         req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   owbm_rsp_type         rsp_data;
   logic                 csr_we;
   logic [CFG_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   one_wire_bus_master dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // model state of the bus master
   logic [CFG_W-1:0] cfg_regs [CFG_COUNT];
   logic [CFG_W-1:0] next_cfg [CFG_COUNT];
   bus_op_type       op_state;
   slot_ph_type      slot_ph;
   logic [CFG_W-1:0] time_left;
   logic [2:0]       bit_idx;
   logic [7:0]       shift_reg;
   logic             pullup_flag;
   logic             presence_lvl;
   logic             line_low;
   logic [7:0]       read_byte;

   owbm_rsp_type pending_bus_rsp [$];
   dir_row_type  dir_rows [$];
   int           err_count;
   int           burst_left;
   int           idle_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [CFG_W-1:0] slot_low_time();
      if (op_state == OP_RESET) return cfg_regs[CFG_RESET_LOW];
      if (op_state == OP_READ) return cfg_regs[CFG_READ_LOW];
      return shift_reg[0] ? cfg_regs[CFG_WRITE_ONE] : cfg_regs[CFG_WRITE_ZERO];
   endfunction

   function automatic void start_slot();
      line_low  = 1'b1;
      slot_ph   = PH_LOW;
      time_left = slot_low_time();
   endfunction

   function automatic void go_idle();
      op_state  = OP_IDLE;
      slot_ph   = PH_LOW;
      time_left = '0;
      bit_idx   = '0;
      line_low  = 1'b0;
   endfunction

   // one item in, one result out; a time of zero behaves like one
   function automatic owbm_rsp_type predict_bus_result(input owbm_req_type it);
      owbm_rsp_type     r;
      logic             done;
      logic             rej;
      logic [CFG_W-1:0] low;
      done = 1'b0;
      rej  = 1'b0;
      if (it.req_type == REQ_TICK) begin
         if (op_state != OP_IDLE) begin
            if (slot_ph == PH_LOW) begin
               if (time_left <= 1) begin
                  line_low = 1'b0;
                  slot_ph  = PH_WAIT;
                  if (op_state == OP_RESET) begin
                     time_left = cfg_regs[CFG_RESET_WAIT];
                  end else if (op_state == OP_READ) begin
                     time_left = cfg_regs[CFG_READ_WAIT];
                  end else begin
                     low = slot_low_time();
                     time_left = (cfg_regs[CFG_SLOT] > low) ? cfg_regs[CFG_SLOT] - low : '0;
                  end
                  if (op_state == OP_WRITE_PU && bit_idx == 3'd7 && cfg_regs[CFG_PULLUP][0])
                     pullup_flag = 1'b1;
               end else begin
                  time_left--;
               end
            end else if (time_left > 1) begin
               time_left--;
            end else if (op_state == OP_RESET) begin
               presence_lvl = it.bus_level;
               go_idle();
               done = 1'b1;
            end else begin
               if (op_state == OP_READ) shift_reg = {it.bus_level, shift_reg[7:1]};
               if (bit_idx == 3'd7) begin
                  if (op_state == OP_READ) read_byte = shift_reg;
                  go_idle();
                  done = 1'b1;
               end else begin
                  if (op_state != OP_READ) shift_reg = shift_reg >> 1;
                  bit_idx++;
                  start_slot();
               end
            end
         end
      end else if (it.req_type <= REQ_SET_PU) begin
         if (op_state != OP_IDLE) begin
            rej = 1'b1;
         end else if (it.req_type == REQ_SET_PU) begin
            if (cfg_regs[CFG_PULLUP][0]) pullup_flag = it.pullup_request;
            done = 1'b1;
         end else begin
            case (it.req_type)
               REQ_RESET:    op_state = OP_RESET;
               REQ_WRITE:    op_state = OP_WRITE;
               REQ_WRITE_PU: op_state = OP_WRITE_PU;
               default:      op_state = OP_READ;
            endcase
            bit_idx = '0;
            if (op_state == OP_WRITE || op_state == OP_WRITE_PU) shift_reg = it.data_byte;
            else if (op_state == OP_READ) shift_reg = '0;
            start_slot();
         end
      end
      r.drive_low         = line_low;
      r.strong_pullup_on  = pullup_flag & cfg_regs[CFG_PULLUP][0];
      r.busy_res          = (op_state != OP_IDLE);
      r.done_res          = done;
      r.byte_read         = read_byte;
      r.reset_sample_high = presence_lvl;
      r.rejected          = rej;
      return r;
   endfunction

   function automatic owbm_req_type mk_req(input logic [2:0] kind, input logic [7:0] data,
                                           input logic level, input logic pu);
      owbm_req_type r;
      r.req_type       = kind;
      r.data_byte      = data;
      r.bus_level      = level;
      r.pullup_request = pu;
      return r;
   endfunction

   function automatic owbm_req_type rand_item(input logic [2:0] kind);
      logic [31:0] rnd;
      rnd = $urandom;
      return mk_req(kind, rnd[7:0], rnd[8], rnd[9]);
   endfunction

   function automatic logic [2:0] rand_kind(input int lo, input int hi);
      logic [31:0] v;
      v = $urandom_range(lo, hi);
      return v[2:0];
   endfunction

   function automatic owbm_rsp_type mk_rsp(input logic drv, input logic spu, input logic busy,
                                           input logic done, input logic [7:0] rd,
                                           input logic rsh, input logic rej);
      owbm_rsp_type r;
      r.drive_low         = drv;
      r.strong_pullup_on  = spu;
      r.busy_res          = busy;
      r.done_res          = done;
      r.byte_read         = rd;
      r.reset_sample_high = rsh;
      r.rejected          = rej;
      return r;
   endfunction

   function automatic logic [CFG_W-1:0] rand_time();
      logic [31:0] v;
      if ($urandom_range(0, 3) == 0) v = $urandom_range(1, 40);
      else v = $urandom_range(1, 4);
      return v[CFG_W-1:0];
   endfunction

   task automatic add_row(input logic reconfig, input owbm_req_type it, input logic lit_en,
                          input owbm_rsp_type lit, input logic drain, input logic drain_level);
      dir_row_type row;
      row.reconfig    = reconfig;
      row.it          = it;
      row.lit_en      = lit_en;
      row.lit         = lit;
      row.drain       = drain;
      row.drain_level = drain_level;
      dir_rows.push_back(row);
   endtask

   // sender works in bursts; valid stays high across a burst
   task automatic send_item(input owbm_req_type it, input logic lit_en, input owbm_rsp_type lit);
      int           gap;
      owbm_rsp_type pred;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
         burst_left = $urandom_range(1, MAX_BURST);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = predict_bus_result(it);
      pending_bus_rsp.push_back(lit_en ? lit : pred);
   endtask

   task automatic settle_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_bus_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic run_to_idle(input logic fixed_en, input logic fixed_level);
      owbm_req_type it;
      while (op_state != OP_IDLE) begin
         it = rand_item(REQ_TICK);
         if (fixed_en) it.bus_level = fixed_level;
         send_item(it, 1'b0, NO_RSP);
      end
   endtask

   task automatic program_regs();
      for (int i = 0; i < CFG_COUNT; i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[CFG_IDX_W-1:0];
         csr_wdata <= next_cfg[i];
         @(posedge clock);
         cfg_regs[i] = (i == CFG_PULLUP) ? {{(CFG_W-1){1'b0}}, next_cfg[i][0]} : next_cfg[i];
      end
      csr_we <= 1'b0;
   endtask

   task automatic random_phase();
      int           sent;
      int           pick;
      logic         paused;
      owbm_req_type it;
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
         if (!paused && sent >= PHASE_ITEMS / 2) begin
            settle_results();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            // a full command with random content, now and then broken by stray items
            send_item(rand_item(rand_kind(REQ_RESET, REQ_SET_PU)), 1'b0, NO_RSP);
            sent++;
            while (op_state != OP_IDLE) begin
               if ($urandom_range(0, 15) == 0) it = rand_item(rand_kind(REQ_RESET, REQ_UNUSED_7));
               else it = rand_item(REQ_TICK);
               send_item(it, 1'b0, NO_RSP);
               sent++;
            end
         end else if (pick < 90) begin
            send_item(rand_item(rand_kind(REQ_TICK, REQ_UNUSED_7)), 1'b0, NO_RSP);
            sent++;
         end else begin
            send_item(rand_item(REQ_TICK), 1'b0, NO_RSP);
         end
      end
   endtask

   // result checker
   always @(posedge clock) begin
      owbm_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bus_rsp.size() == 0) begin
            err_count++;
            if (err_count <= MAX_PRINTS)
               $display("%0t: unexpected result %h, nothing pending", $time, rsp_data);
         end else begin
            want = pending_bus_rsp.pop_front();
            if (rsp_data !== want) begin
               err_count++;
               if (err_count <= MAX_PRINTS)
                  $display({"%0t: mismatch expected drv=%b spu=%b busy=%b done=%b byte=%h",
                            " rsh=%b rej=%b, got drv=%b spu=%b busy=%b done=%b byte=%h",
                            " rsh=%b rej=%b"},
                           $time, want.drive_low, want.strong_pullup_on, want.busy_res,
                           want.done_res, want.byte_read, want.reset_sample_high, want.rejected,
                           rsp_data.drive_low, rsp_data.strong_pullup_on, rsp_data.busy_res,
                           rsp_data.done_res, rsp_data.byte_read, rsp_data.reset_sample_high,
                           rsp_data.rejected);
            end
         end
      end
   end

   // watchdog on transfers
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // receiver stall pattern
   initial begin : rsp_stall_gen
      int mode;
      int span;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 120);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 1) == 1);
               2:       rsp_stall <= ($urandom_range(0, 7) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      dir_row_type row;
      logic [31:0] rnd;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      burst_left  = 0;

      cfg_regs[CFG_RESET_LOW]  = RST_RESET_LOW;
      cfg_regs[CFG_RESET_WAIT] = RST_RESET_WAIT;
      cfg_regs[CFG_WRITE_ONE]  = RST_WRITE_ONE;
      cfg_regs[CFG_WRITE_ZERO] = RST_WRITE_ZERO;
      cfg_regs[CFG_SLOT]       = RST_SLOT;
      cfg_regs[CFG_READ_LOW]   = RST_READ_LOW;
      cfg_regs[CFG_READ_WAIT]  = RST_READ_WAIT;
      cfg_regs[CFG_PULLUP]     = '0;
      go_idle();
      shift_reg    = '0;
      pullup_flag  = 1'b0;
      presence_lvl = 1'b1;
      read_byte    = '0;

      // default timing, no pull-up fitted
      add_row(1'b0, mk_req(REQ_TICK, 8'h00, 1'b1, 1'b0), 1'b1,
              mk_rsp(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0), 1'b0, 1'b0);
      add_row(1'b0, mk_req(REQ_UNUSED_6, 8'h00, 1'b0, 1'b0), 1'b1,
              mk_rsp(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0), 1'b0, 1'b0);
      add_row(1'b0, mk_req(REQ_UNUSED_7, 8'hFF, 1'b1, 1'b1), 1'b1,
              mk_rsp(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0), 1'b0, 1'b0);
      add_row(1'b0, mk_req(REQ_SET_PU, 8'h00, 1'b0, 1'b1), 1'b1,
              mk_rsp(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0), 1'b0, 1'b0);
      add_row(1'b0, mk_req(REQ_RESET, 8'h00, 1'b0, 1'b0), 1'b1,
              mk_rsp(1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0), 1'b0, 1'b0);
      add_row(1'b0, mk_req(REQ_WRITE, 8'hAA, 1'b0, 1'b0), 1'b1,
              mk_rsp(1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1), 1'b0, 1'b0);
      add_row(1'b0, mk_req(REQ_SET_PU, 8'h00, 1'b0, 1'b1), 1'b1,
              mk_rsp(1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1), 1'b0, 1'b0);
      add_row(1'b0, mk_req(REQ_UNUSED_7, 8'h00, 1'b0, 1'b0), 1'b1,
              mk_rsp(1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0), 1'b0, 1'b0);
      add_row(1'b0, mk_req(REQ_TICK, 8'h00, 1'b0, 1'b0), 1'b0, NO_RSP, 1'b1, 1'b0);
      // all times at their minimum, pull-up fitted
      add_row(1'b1, mk_req(REQ_SET_PU, 8'h00, 1'b0, 1'b1), 1'b1,
              mk_rsp(1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0), 1'b0, 1'b0);
      add_row(1'b0, mk_req(REQ_WRITE_PU, 8'hFF, 1'b0, 1'b0), 1'b0, NO_RSP, 1'b1, 1'b1);
      add_row(1'b0, mk_req(REQ_SET_PU, 8'h00, 1'b0, 1'b0), 1'b1,
              mk_rsp(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0), 1'b0, 1'b0);
      add_row(1'b0, mk_req(REQ_WRITE, 8'h00, 1'b0, 1'b0), 1'b0, NO_RSP, 1'b1, 1'b1);
      add_row(1'b0, mk_req(REQ_READ, 8'h00, 1'b0, 1'b0), 1'b0, NO_RSP, 1'b1, 1'b1);
      add_row(1'b0, mk_req(REQ_TICK, 8'h00, 1'b0, 1'b0), 1'b1,
              mk_rsp(1'b0, 1'b0, 1'b0, 1'b0, 8'hFF, 1'b0, 1'b0), 1'b0, 1'b0);
      add_row(1'b0, mk_req(REQ_READ, 8'hFF, 1'b1, 1'b1), 1'b0, NO_RSP, 1'b1, 1'b0);
      add_row(1'b0, mk_req(REQ_RESET, 8'h00, 1'b0, 1'b0), 1'b0, NO_RSP, 1'b1, 1'b1);
      add_row(1'b0, mk_req(REQ_TICK, 8'h00, 1'b1, 1'b0), 1'b1,
              mk_rsp(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0), 1'b0, 1'b0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.reconfig) begin
            settle_results();
            for (int k = 0; k < CFG_COUNT; k++) next_cfg[k] = 12'd1;
            program_regs();
         end
         send_item(row.it, row.lit_en, row.lit);
         if (row.drain) run_to_idle(1'b1, row.drain_level);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle_results();
         if (p == LONG_PHASE) begin
            // one fixed time everywhere: the write slot equals its low time, so the wait time is zero
            for (int k = 0; k < CFG_COUNT; k++) next_cfg[k] = LONG_TIME;
            next_cfg[CFG_PULLUP] = 12'd1;
            program_regs();
            send_item(rand_item(REQ_WRITE_PU), 1'b0, NO_RSP);
            run_to_idle(1'b0, 1'b0);
            send_item(rand_item(REQ_READ), 1'b0, NO_RSP);
            run_to_idle(1'b0, 1'b0);
            send_item(rand_item(REQ_RESET), 1'b0, NO_RSP);
            run_to_idle(1'b0, 1'b0);
            send_item(rand_item(REQ_SET_PU), 1'b0, NO_RSP);
         end else begin
            for (int k = 0; k < CFG_COUNT; k++) next_cfg[k] = rand_time();
            rnd = $urandom;
            next_cfg[CFG_PULLUP] = rnd[CFG_W-1:0];
            program_regs();
            random_phase();
            run_to_idle(1'b0, 1'b0);
         end
      end

      settle_results();
      repeat (8) @(posedge clock);
      if (err_count == 0 && pending_bus_rsp.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
